// ----- rtl/core/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants for the insertion sort engine.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W     = 32;
    localparam int PLEN_W     = 7;
    localparam logic [PLEN_W-1:0] PLEN_RESET = 7'd64;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_HELD_RD = 7'b0000010,
        ST_HELD_LD = 7'b0000100,
        ST_CMP     = 7'b0001000,
        ST_PLACE   = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_LD = 7'b1000000
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     overflow;
    } t_out_beat;

endpackage

// ----- rtl/core/iss_ram.sv -----
// ----------------------------------------------------------------------------
// iss_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module iss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/iss_out_stage.sv -----
// ----------------------------------------------------------------------------
// iss_out_stage
// Output register holding one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module iss_out_stage
    import iss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_out_beat         i_beat,
    output logic              o_free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] value_out
    output logic              m_axis_tlast,   // last_out
    output logic              m_axis_tuser    // [0] overflow
);

    logic      r_valid;
    t_out_beat r_beat;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_beat.value;
    assign m_axis_tlast  = r_beat.last;
    assign m_axis_tuser  = r_beat.overflow;

endmodule

// ----- rtl/core/insertion_sort_engine.sv -----
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Collects signed values into a memory, sorts a leading prefix and streams
// the whole set out.
// ----------------------------------------------------------------------------
// Values arrive one beat per cycle while the engine is idle and are written
// to the element memory in arrival order; beats beyond DEPTH are dropped and
// flag overflow on every result of that set. The beat with tlast starts a
// stable ascending insertion sort of the first min(prefix_len, count)
// positions, then every stored element streams out in position order with
// tlast on the final one. The sort runs on the single memory read port:
// inserting element i reads it, then writes each larger entry one position
// right before placing element i in the gap. Each output element is read
// from memory, then loaded into the output register. Collection of the next
// set may begin once the final result sits in the output register.
// ----------------------------------------------------------------------------
module insertion_sort_engine
    import iss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PLEN_W-1:0] cfg_data,       // prefix_len
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic              s_axis_tlast,   // end_of_set
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] value_out
    output logic              m_axis_tlast,   // last_out
    output logic              m_axis_tuser    // [0] overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                   r_state, n_state;
    logic [PLEN_W-1:0]        r_prefix;
    logic [CW-1:0]            r_fill, n_fill;
    logic                     r_dropped, n_dropped;
    logic [CW-1:0]            r_k, n_k;
    logic [CW-1:0]            r_i, n_i;
    logic [AW-1:0]            r_pos, n_pos;
    logic [AW-1:0]            r_j, n_j;
    logic signed [DATA_W-1:0] r_held, n_held;

    logic                     in_beat;
    logic [CW-1:0]            fill_inc;
    logic [CW-1:0]            k_set;
    logic [CW-1:0]            i_inc;
    logic [AW-1:0]            last_idx;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [AW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     out_free;
    logic                     out_load;
    t_out_beat                out_beat;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign fill_inc = (r_fill < CW'(DEPTH)) ? r_fill + 1'b1 : r_fill;
    assign k_set    = (PLEN_W'(fill_inc) <= r_prefix) ? fill_inc : CW'(r_prefix);
    assign i_inc    = r_i + 1'b1;
    assign last_idx = AW'(r_fill - 1'b1);

    iss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    iss_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_beat        (out_beat),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_dropped = r_dropped;
        n_k       = r_k;
        n_i       = r_i;
        n_pos     = r_pos;
        n_j       = r_j;
        n_held    = r_held;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_held;
        rd_addr   = r_j;
        out_load  = 1'b0;
        out_beat.value    = rd_data;
        out_beat.last     = (r_j == last_idx);
        out_beat.overflow = r_dropped;

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if (r_fill < CW'(DEPTH)) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_fill);
                        wr_data = s_axis_tdata;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    n_fill = fill_inc;
                    if (s_axis_tlast) begin
                        n_k = k_set;
                        n_j = '0;
                        if (k_set > CW'(1)) begin
                            n_i     = CW'(1);
                            n_state = ST_HELD_RD;
                        end else begin
                            n_state = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_HELD_RD: begin
                rd_addr = AW'(r_i);
                n_state = ST_HELD_LD;
            end
            ST_HELD_LD: begin
                rd_addr = AW'(r_i - 1'b1);
                n_held  = rd_data;
                n_pos   = AW'(r_i);
                n_state = ST_CMP;
            end
            ST_CMP: begin
                rd_addr = r_pos - AW'(2);
                wr_en   = 1'b1;
                wr_addr = r_pos;
                if (rd_data > r_held) begin
                    wr_data = rd_data;
                    n_pos   = r_pos - 1'b1;
                    if (r_pos == AW'(1)) begin
                        n_state = ST_PLACE;
                    end
                end else begin
                    wr_data = r_held;
                    n_i     = i_inc;
                    n_state = (i_inc < r_k) ? ST_HELD_RD : ST_EMIT_RD;
                end
            end
            ST_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_held;
                n_i     = i_inc;
                n_state = (i_inc < r_k) ? ST_HELD_RD : ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_j == last_idx) begin
                        n_fill    = '0;
                        n_dropped = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_prefix  <= PLEN_RESET;
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_dropped <= n_dropped;
            if (cfg_valid && cfg_ready) begin
                r_prefix <= cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_i    <= n_i;
        r_pos  <= n_pos;
        r_j    <= n_j;
        r_held <= n_held;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CMP |-> r_pos != '0)
        else $error("compare with no left neighbor");

    a_sort_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HELD_RD || r_state == ST_CMP || r_state == ST_PLACE)
        |-> (r_i < r_k && r_i != '0))
        else $error("insertion index outside prefix");

    a_last_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_LD && out_free && r_j == last_idx)
        |=> (m_axis_tvalid && m_axis_tlast && r_fill == '0))
        else $error("final beat not flagged");

endmodule
